/* rtl/content_defined_chunker_assert.svh */
// Assertion macros shared by the chunker RTL.
`ifndef CONTENT_DEFINED_CHUNKER_ASSERT_SVH
`define CONTENT_DEFINED_CHUNKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define CDC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define CDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/cdc_pkg.sv */
// Shared constants, register indexes and the ELF hash step for the chunker.
package cdc_pkg;

    // Hash stays below 2^28 after every update step
    localparam int HASH_W   = 28;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 7;
    localparam int REASON_W = 2;
    localparam int OUT_FIELD_W = 16;
    localparam int WIN_CNT_W = 7;
    localparam int REM_CFG_W = 6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_WINDOWS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_WINDOWS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_REMAINDER = 2'd2;

    // Register reset values
    localparam logic [WIN_CNT_W-1:0] MIN_WINDOWS_RST     = 7'd8;
    localparam logic [WIN_CNT_W-1:0] MAX_WINDOWS_RST     = 7'd12;
    localparam logic [REM_CFG_W-1:0] MATCH_REMAINDER_RST = 6'd22;

    // Cut reason codes
    localparam logic [REASON_W-1:0] REASON_HASH = 2'd0;
    localparam logic [REASON_W-1:0] REASON_MAX  = 2'd1;
    localparam logic [REASON_W-1:0] REASON_EOS  = 2'd2;

    // One ELF hash step with the byte sign-extended
    function automatic logic [HASH_W-1:0] elf_mix(input logic [HASH_W-1:0] h,
                                                  input logic [7:0] b);
        logic [31:0] t;
        t = {h, 4'b0000} + {{24{b[7]}}, b};
        if (t[31:28] != 4'b0000)
            elf_mix = t[27:0] ^ {20'b0, t[31:28], 4'b0000};
        else
            elf_mix = t[27:0];
    endfunction

endpackage

/* rtl/content_defined_chunker.sv */
// Content-defined chunker: ELF window hash, chunk cut decision and result output.
//
// Usage:
//   Bytes enter on the s_ stream, one per request; s_tlast marks the last byte
//   of a file. Every cut produces one request on the m_ stream carrying the
//   chunk length (saturated at 65535), chunk sequence number and cut reason.
//   The user writes registers over the cfg_ channel (always ready) only while
//   idle; the block does not enforce it. Unlisted indexes are ignored.
// Timing:
//   One byte is taken every cycle while m_ does not stall. A result appears
//   on m_ once its byte has passed each registered step in turn: the edge
//   that accepts the byte captures the hash update, then quotient multiply,
//   remainder and match, and the cut decision into the output register follow.
//   The hash modulo is a reciprocal multiply followed by a multiply-subtract,
//   one multiplier per stage, so the rate is set by nothing but the pipeline.
// Reset:
//   rst_n clears the hash, counters, pipeline valids and loads the register
//   defaults (8, 12, 22). No clearing pass is needed.
// Stall:
//   A held result keeps m_ stable; the three pipeline stages still fill, so up
//   to three more bytes are taken before s_tready drops.
module content_defined_chunker #(
    parameter int WINDOW_BYTES = 512,
    parameter int HASH_DIVISOR = 44
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input byte stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] data_byte
    input  logic                              s_tlast,   // end_of_stream
    // Chunk result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [2*cdc_pkg::OUT_FIELD_W-1:0] m_tdata,   // [15:0] chunk_length,
                                                         // [31:16] chunk_index
    output logic [cdc_pkg::REASON_W-1:0]      m_tuser,   // [1:0] cut_reason
    // Register write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cdc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cdc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import cdc_pkg::*;

    `include "content_defined_chunker_assert.svh"

    localparam int BIW_W   = $clog2(WINDOW_BYTES + 1);
    localparam int LEN_RAW = $clog2(128 * WINDOW_BYTES + 1);
    localparam int LEN_W   = (LEN_RAW > OUT_FIELD_W + 1) ? LEN_RAW : OUT_FIELD_W + 1;
    localparam int DIV_L   = $clog2(HASH_DIVISOR);
    localparam int DIV_S   = HASH_W + DIV_L;
    localparam int RECIP_W = HASH_W + 1;
    localparam int PROD_W  = HASH_W + RECIP_W;
    localparam logic [63:0] RECIP64 =
        ((64'd1 << DIV_S) + 64'(HASH_DIVISOR) - 64'd1) / 64'(HASH_DIVISOR);
    localparam logic [RECIP_W-1:0] RECIP = RECIP64[RECIP_W-1:0];
    localparam int REM_W   = (DIV_L > 0) ? DIV_L : 1;
    localparam int CMP_W   = (REM_W > REM_CFG_W) ? REM_W : REM_CFG_W;

    // Configuration registers
    logic [WIN_CNT_W-1:0] min_win_reg;
    logic [WIN_CNT_W-1:0] max_win_reg;
    logic [REM_CFG_W-1:0] match_rem_reg;

    // Front state
    logic [HASH_W-1:0] hash_reg, hash_next;
    logic [BIW_W-1:0]  biw_reg, biw_next;

    // Pipeline stages
    logic              p1_v_reg, p2_v_reg, p3_v_reg;
    logic [HASH_W-1:0] p1_hash_reg, p2_hash_reg;
    logic [HASH_W-1:0] p2_q_reg;
    logic              p1_wend_reg, p2_wend_reg, p3_wend_reg;
    logic              p1_eos_reg, p2_eos_reg, p3_eos_reg;
    logic [BIW_W-1:0]  p1_biw_reg, p2_biw_reg, p3_biw_reg;
    logic              p3_match_reg;

    // Back state and output
    logic [WIN_CNT_W-1:0]   wic_reg;
    logic [OUT_FIELD_W-1:0] chunk_cnt_reg;
    logic                   out_v_reg;
    logic [OUT_FIELD_W-1:0] out_len_reg, out_idx_reg;
    logic [REASON_W-1:0]    out_reason_reg;

    logic en_out, en_p3, en_p2, accept;
    logic [HASH_W-1:0] mix_hash;
    logic [BIW_W-1:0]  biw_inc;
    logic              wend;

    // Stage advance chain; bubbles let input flow while a result waits
    assign en_out    = !out_v_reg || m_tready;
    assign en_p3     = !p3_v_reg || en_out;
    assign en_p2     = !p2_v_reg || en_p3;
    assign s_tready  = !p1_v_reg || en_p2;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_win_reg   <= MIN_WINDOWS_RST;
            max_win_reg   <= MAX_WINDOWS_RST;
            match_rem_reg <= MATCH_REMAINDER_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MIN_WINDOWS:     min_win_reg   <= cfg_data;
                REG_MAX_WINDOWS:     max_win_reg   <= cfg_data;
                REG_MATCH_REMAINDER: match_rem_reg <= cfg_data[REM_CFG_W-1:0];
                default:             ;
            endcase
        end
    end

    // Hash step and window position; clear at window end and end of stream
    always_comb
    begin
        mix_hash  = elf_mix(hash_reg, s_tdata);
        biw_inc   = biw_reg + BIW_W'(1);
        wend      = (biw_inc == BIW_W'(WINDOW_BYTES));
        hash_next = hash_reg;
        biw_next  = biw_reg;
        if (accept)
        begin
            hash_next = (wend || s_tlast) ? '0 : mix_hash;
            biw_next  = (wend || s_tlast) ? '0 : biw_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= '0;
            biw_reg  <= '0;
        end
        else
        begin
            hash_reg <= hash_next;
            biw_reg  <= biw_next;
        end
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                p1_v_reg <= s_tvalid;
            if (en_p2)
                p2_v_reg <= p1_v_reg;
            if (en_p3)
                p3_v_reg <= p2_v_reg;
        end
    end

    // Stage 1: capture the updated hash and item flags
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_hash_reg <= mix_hash;
            p1_wend_reg <= wend;
            p1_eos_reg  <= s_tlast;
            p1_biw_reg  <= biw_inc;
        end
    end

    // Stage 2: quotient by reciprocal multiply
    logic [PROD_W-1:0] quot_prod;
    assign quot_prod = PROD_W'(p1_hash_reg) * PROD_W'(RECIP);

    always_ff @(posedge clk)
    begin
        if (en_p2)
        begin
            p2_hash_reg <= p1_hash_reg;
            p2_q_reg    <= HASH_W'(quot_prod >> DIV_S);
            p2_wend_reg <= p1_wend_reg;
            p2_eos_reg  <= p1_eos_reg;
            p2_biw_reg  <= p1_biw_reg;
        end
    end

    // Stage 3: remainder and match against the boundary value
    logic [HASH_W-1:0] quot_back, rem_full;
    logic              rem_match;
    assign quot_back = HASH_W'(p2_q_reg * HASH_W'(HASH_DIVISOR));
    assign rem_full  = p2_hash_reg - quot_back;
    assign rem_match = (CMP_W'(rem_full[REM_W-1:0]) == CMP_W'(match_rem_reg));

    always_ff @(posedge clk)
    begin
        if (en_p3)
        begin
            p3_match_reg <= rem_match;
            p3_wend_reg  <= p2_wend_reg;
            p3_eos_reg   <= p2_eos_reg;
            p3_biw_reg   <= p2_biw_reg;
        end
    end

    // Cut decision: forced size first, then hash match, then end of stream
    logic [WIN_CNT_W-1:0] wic_inc, wic_next;
    logic [LEN_W-1:0]     len_full;
    logic [OUT_FIELD_W-1:0] len_sat;
    logic                 cut;
    logic [REASON_W-1:0]  reason;
    logic                 load;

    always_comb
    begin
        wic_inc  = wic_reg + WIN_CNT_W'(1);
        len_full = LEN_W'(wic_reg) * LEN_W'(WINDOW_BYTES) + LEN_W'(p3_biw_reg);
        len_sat  = (len_full > LEN_W'({OUT_FIELD_W{1'b1}})) ? {OUT_FIELD_W{1'b1}}
                                                          : len_full[OUT_FIELD_W-1:0];
        cut      = 1'b0;
        reason   = REASON_EOS;
        if (p3_wend_reg)
        begin
            if (wic_inc >= max_win_reg)
            begin
                cut    = 1'b1;
                reason = REASON_MAX;
            end
            else if (wic_inc >= min_win_reg && p3_match_reg)
            begin
                cut    = 1'b1;
                reason = REASON_HASH;
            end
        end
        if (p3_eos_reg && !cut)
        begin
            cut    = 1'b1;
            reason = REASON_EOS;
        end
        wic_next = wic_reg;
        if (cut)
            wic_next = '0;
        else if (p3_wend_reg)
            wic_next = wic_inc;
        load = p3_v_reg && en_out;
    end

    // Back state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wic_reg       <= '0;
            chunk_cnt_reg <= '0;
            out_v_reg     <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                wic_reg <= wic_next;
                if (cut)
                    chunk_cnt_reg <= chunk_cnt_reg + OUT_FIELD_W'(1);
            end
            if (en_out)
                out_v_reg <= load && cut;
        end
    end

    // Output payload; hold while stalled
    always_ff @(posedge clk)
    begin
        if (load && cut)
        begin
            out_len_reg    <= len_sat;
            out_idx_reg    <= chunk_cnt_reg;
            out_reason_reg <= reason;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {out_idx_reg, out_len_reg};
    assign m_tuser  = out_reason_reg;

    // Checks
    `CDC_ASSERT_NEXT(a_eos_clears_front, accept && s_tlast,
        hash_reg == '0 && biw_reg == '0, "front state not cleared after end of stream")
    `CDC_ASSERT_NOW(a_index_tracks_counter, m_tvalid,
        chunk_cnt_reg == OUT_FIELD_W'(m_tdata[31:16] + 16'd1), "chunk counter out of step")
    `CDC_ASSERT_NOW(a_length_nonzero, m_tvalid,
        m_tdata[15:0] != 16'd0 && m_tuser <= REASON_EOS, "empty chunk or bad reason")

endmodule
